// File: rtl/core/snell_refraction_vector_top_macros.svh
// ----------------------------------------------------------------------------
// snell refraction assertion macros
// shared concurrent assertion shapes for the refraction block
// ----------------------------------------------------------------------------
`ifndef SNELL_REFRACTION_VECTOR_TOP_MACROS_SVH
`define SNELL_REFRACTION_VECTOR_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SRV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define SRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/srv_pkg.sv
// ----------------------------------------------------------------------------
// srv_pkg
// shared widths and constants for the snell refraction block
// ----------------------------------------------------------------------------
`default_nettype none
package srv_pkg;
    localparam int FracBits = 12;
    localparam int SqrtSteps = 2;
    localparam int DivSteps = 4;
    localparam int LenRadW = 66;
    localparam int LenRootW = 33;
    localparam int DivQW = 32;
    localparam int DiscRadW = 36;
    localparam int DiscRootW = 18;
    localparam int UnitW = 18;

    // truncated integer square root state
    typedef struct packed {
        logic [LenRadW-1:0]  rem;
        logic [LenRootW-1:0] root;
    } t_len_sqrt;

    // one integer square-root step (one radicand bit pair in, one result bit out)
    function automatic logic [LenRadW+LenRootW-1:0] sqrt_step(
        input logic [LenRadW-1:0] rem,
        input logic [LenRootW-1:0] root,
        input logic [1:0] pair
    );
        logic [LenRadW+1:0]  trial_rem;
        logic [LenRadW+1:0]  trial;
        logic [LenRadW-1:0]  n_rem;
        logic [LenRootW-1:0] n_root;
        trial_rem = {rem, pair};
        trial = {{(LenRadW-LenRootW){1'b0}}, root, 2'b01};
        if (trial_rem >= trial) begin
            n_rem = LenRadW'(trial_rem - trial);
            n_root = {root[LenRootW-2:0], 1'b1};
        end else begin
            n_rem = LenRadW'(trial_rem);
            n_root = {root[LenRootW-2:0], 1'b0};
        end
        return {n_rem, n_root};
    endfunction

    // divide by 2^FracBits, halves away from zero
    function automatic logic signed [47:0] rnd_f(input logic signed [47:0] v);
        logic [47:0] m;
        m = v[47] ? 48'(-v) : 48'(v);
        m = (m + 48'(1 << (FracBits - 1))) >> FracBits;
        return v[47] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767) return 16'sh7fff;
        if (v < -48'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction
endpackage
`default_nettype wire

// File: rtl/core/srv_len.sv
// ----------------------------------------------------------------------------
// srv_len
// squared length and pipelined square root of the incident vector
// ----------------------------------------------------------------------------
`default_nettype none
module srv_len import srv_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [15:0]  i_dx,
    input  wire logic signed [15:0]  i_dy,
    input  wire logic signed [15:0]  i_dz,
    output logic [32:0]              o_len2,
    output logic [LenRootW-1:0]      o_root
);
    // 33 result bits, one per step, spread over stages
    localparam int Pairs = LenRootW;
    localparam int PerStage = 6;
    localparam int Stages = (Pairs + PerStage - 1) / PerStage;

    logic [32:0] r_len2 [0:Stages];
    logic [LenRadW-1:0] r_rem [0:Stages];
    logic [LenRootW-1:0] r_root [0:Stages];
    logic [33:0] n_len2;

    assign n_len2 = 34'($signed(i_dx) * $signed(i_dx)) + 34'($signed(i_dy) * $signed(i_dy))
                  + 34'($signed(i_dz) * $signed(i_dz));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len2[0] <= n_len2[32:0];
            r_rem[0] <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar s = 0; s < Stages; s++) begin : g_st
        logic [LenRadW-1:0] c_rem [0:PerStage];
        logic [LenRootW-1:0] c_root [0:PerStage];
        logic [LenRadW-1:0] rad;
        // radicand is the squared length scaled by 2^32
        assign rad = {1'b0, r_len2[s], 32'b0};
        assign c_rem[0] = r_rem[s];
        assign c_root[0] = r_root[s];
        for (genvar p = 0; p < PerStage; p++) begin : g_p
            localparam int Idx = Pairs - 1 - (s * PerStage + p);
            if (Idx >= 0) begin : g_do
                assign {c_rem[p+1], c_root[p+1]} =
                    sqrt_step(c_rem[p], c_root[p], rad[2*Idx+1:2*Idx]);
            end else begin : g_pass
                assign c_rem[p+1] = c_rem[p];
                assign c_root[p+1] = c_root[p];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_len2[s+1] <= r_len2[s];
                r_rem[s+1] <= c_rem[PerStage];
                r_root[s+1] <= c_root[PerStage];
            end
        end
    end

    assign o_len2 = r_len2[Stages];
    assign o_root = r_root[Stages];
endmodule
`default_nettype wire

// File: rtl/core/srv_div.sv
// ----------------------------------------------------------------------------
// srv_div
// pipelined restoring divider for one normalised component
// ----------------------------------------------------------------------------
`default_nettype none
module srv_div import srv_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [15:0]        i_mag,
    input  wire logic               i_neg,
    input  wire logic [LenRootW-1:0] i_den,
    output logic signed [UnitW-1:0] o_unit
);
    // numerator (mag << 28) + den/2, quotient below 2^18
    localparam int NumW = 16 + FracBits + 16 + 1;
    localparam int QW = UnitW;
    localparam int PerStage = 3;
    localparam int Stages = (QW + PerStage - 1) / PerStage;
    localparam int RemW = LenRootW + 1;

    logic [NumW-1:0] r_num [0:Stages];
    logic [RemW-1:0] r_rem [0:Stages];
    logic [QW-1:0] r_q [0:Stages];
    logic [LenRootW-1:0] r_den [0:Stages];
    logic r_neg [0:Stages];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= NumW'({i_mag, (FracBits + 16)'(0)}) + NumW'(i_den >> 1);
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_q[0] <= '0;
            // high bits above the quotient width are always below den
            r_rem[0] <= RemW'(({i_mag, (FracBits + 16)'(0)} + (NumW)'(i_den >> 1)) >> QW);
        end
    end

    for (genvar s = 0; s < Stages; s++) begin : g_st
        logic [RemW-1:0] c_rem [0:PerStage];
        logic [QW-1:0] c_q [0:PerStage];
        assign c_rem[0] = r_rem[s];
        assign c_q[0] = r_q[s];
        for (genvar p = 0; p < PerStage; p++) begin : g_p
            localparam int Bit = QW - 1 - (s * PerStage + p);
            if (Bit >= 0) begin : g_do
                logic [RemW:0] t;
                assign t = {c_rem[p], r_num[s][Bit]};
                assign c_rem[p+1] = (t >= (RemW+1)'(r_den[s])) ?
                    RemW'(t - (RemW+1)'(r_den[s])) : RemW'(t);
                assign c_q[p+1] = {c_q[p][QW-2:0], (t >= (RemW+1)'(r_den[s]))};
            end else begin : g_pass
                assign c_rem[p+1] = c_rem[p];
                assign c_q[p+1] = c_q[p];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[s+1] <= r_num[s];
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_rem[s+1] <= c_rem[PerStage];
                r_q[s+1] <= c_q[PerStage];
            end
        end
    end

    assign o_unit = r_neg[Stages] ? -$signed(r_q[Stages]) : $signed(r_q[Stages]);
endmodule
`default_nettype wire

// File: rtl/core/srv_snell.sv
// ----------------------------------------------------------------------------
// srv_snell
// dot product, discriminant, root and output combination stages
// ----------------------------------------------------------------------------
`default_nettype none
module srv_snell import srv_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic                   i_zero,
    input  wire logic signed [UnitW-1:0] i_ux,
    input  wire logic signed [UnitW-1:0] i_uy,
    input  wire logic signed [UnitW-1:0] i_uz,
    input  wire logic signed [13:0]     i_nx,
    input  wire logic signed [13:0]     i_ny,
    input  wire logic signed [13:0]     i_nz,
    input  wire logic [14:0]            i_r,
    output logic signed [15:0]          o_x,
    output logic signed [15:0]          o_y,
    output logic signed [15:0]          o_z,
    output logic                        o_ok
);
    typedef struct packed {
        logic signed [UnitW-1:0] ux, uy, uz;
        logic signed [13:0] nx, ny, nz;
        logic [14:0] r;
        logic zero;
    } t_base;

    localparam int QStages = 3;

    // stage a: dot product and r squared
    t_base r_a;
    logic signed [23:0] r_dot_a;
    logic signed [23:0] r_r2_a;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= '{i_ux, i_uy, i_uz, i_nx, i_ny, i_nz, i_r, i_zero};
            r_dot_a <= 24'(rnd_f(48'(i_ux * i_nx) + 48'(i_uy * i_ny)
                + 48'(i_uz * i_nz)));
            r_r2_a <= 24'(rnd_f(48'($signed({1'b0, i_r}) * $signed({1'b0, i_r}))));
        end
    end

    // stage b: one minus dot squared (sine-squared term) and tangents
    t_base r_b;
    logic signed [23:0] r_r2_b, r_c_b;
    logic signed [23:0] r_tx, r_ty, r_tz;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= r_a;
            r_r2_b <= r_r2_a;
            r_c_b <= 24'(rnd_f(48'(1 << (2 * FracBits)) - r_dot_a * r_dot_a));
            r_tx <= 24'(48'(r_a.ux) - rnd_f(48'(r_a.nx) * r_dot_a));
            r_ty <= 24'(48'(r_a.uy) - rnd_f(48'(r_a.ny) * r_dot_a));
            r_tz <= 24'(48'(r_a.uz) - rnd_f(48'(r_a.nz) * r_dot_a));
        end
    end

    // stage c: k and discriminant
    t_base r_c;
    logic signed [47:0] r_disc;
    logic signed [23:0] r_tx_c, r_ty_c, r_tz_c;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= r_b;
            r_disc <= 48'(1 << FracBits) - rnd_f(r_r2_b * r_c_b);
            r_tx_c <= r_tx;
            r_ty_c <= r_ty;
            r_tz_c <= r_tz;
        end
    end

    // stage d: scaled tangents, square root over QStages stages
    logic ok_d;
    logic [DiscRadW-1:0] rad_d;
    assign ok_d = !r_c.zero && (r_disc > 0);
    assign rad_d = ok_d ? DiscRadW'({r_disc, (FracBits)'(0)}) : '0;

    t_base r_q [0:QStages];
    logic r_ok [0:QStages];
    logic [DiscRadW-1:0] r_rad [0:QStages];
    logic [LenRadW-1:0] r_rem [0:QStages];
    logic [LenRootW-1:0] r_root [0:QStages];
    logic signed [47:0] r_sx [0:QStages];
    logic signed [47:0] r_sy [0:QStages];
    logic signed [47:0] r_sz [0:QStages];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= r_c;
            r_ok[0] <= ok_d;
            r_rad[0] <= rad_d;
            r_rem[0] <= '0;
            r_root[0] <= '0;
            r_sx[0] <= rnd_f(48'($signed({1'b0, r_c.r})) * r_tx_c);
            r_sy[0] <= rnd_f(48'($signed({1'b0, r_c.r})) * r_ty_c);
            r_sz[0] <= rnd_f(48'($signed({1'b0, r_c.r})) * r_tz_c);
        end
    end

    localparam int PerStage = (DiscRootW + QStages - 1) / QStages;
    for (genvar s = 0; s < QStages; s++) begin : g_q
        logic [LenRadW-1:0] c_rem [0:PerStage];
        logic [LenRootW-1:0] c_root [0:PerStage];
        assign c_rem[0] = r_rem[s];
        assign c_root[0] = r_root[s];
        for (genvar p = 0; p < PerStage; p++) begin : g_p
            localparam int Idx = DiscRootW - 1 - (s * PerStage + p);
            if (Idx >= 0) begin : g_do
                assign {c_rem[p+1], c_root[p+1]} =
                    sqrt_step(c_rem[p], c_root[p], r_rad[s][2*Idx+1:2*Idx]);
            end else begin : g_pass
                assign c_rem[p+1] = c_rem[p];
                assign c_root[p+1] = c_root[p];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1] <= r_q[s];
                r_ok[s+1] <= r_ok[s];
                r_rad[s+1] <= r_rad[s];
                r_rem[s+1] <= c_rem[PerStage];
                r_root[s+1] <= c_root[PerStage];
                r_sx[s+1] <= r_sx[s];
                r_sy[s+1] <= r_sy[s];
                r_sz[s+1] <= r_sz[s];
            end
        end
    end

    // stage e: combine and saturate
    logic signed [47:0] qv;
    assign qv = 48'(r_root[QStages]);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ok <= r_ok[QStages];
            o_x <= r_ok[QStages] ?
                sat16(r_sx[QStages] - rnd_f(48'(r_q[QStages].nx) * qv)) : '0;
            o_y <= r_ok[QStages] ?
                sat16(r_sy[QStages] - rnd_f(48'(r_q[QStages].ny) * qv)) : '0;
            o_z <= r_ok[QStages] ?
                sat16(r_sz[QStages] - rnd_f(48'(r_q[QStages].nz) * qv)) : '0;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/snell_refraction_vector_top.sv
// ----------------------------------------------------------------------------
// snell_refraction_vector_top
// streaming vector refraction by snell's law in q4.12 fixed point
// ----------------------------------------------------------------------------
// one item enters per clock while the output is not stalled, and one result
// item leaves per item, in order, after the length root, the normalising
// divider, then dot product, discriminant, its root and the output stage;
// throughput is one item a cycle when not stalled, set by the fully pipelined
// length root, normalising divider and discriminant root. a stall on the
// output freezes the whole pipeline, and valid bits travel with each item so
// nothing is lost or repeated
`default_nettype none
`include "snell_refraction_vector_top_macros.svh"
module snell_refraction_vector_top import srv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio, zero pad
    input  wire logic [111:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_x, out_y, out_z, valid_res, zero pad
    output logic [55:0]      m_axis_tdata
);
    localparam int LenLat = 1 + (LenRootW + 5) / 6;
    localparam int DivLat = 1 + (UnitW + 2) / 3;
    localparam int SnLat = 3 + 1 + 3 + 1;
    localparam int Lat = LenLat + DivLat + SnLat;

    logic en;
    logic [Lat-1:0] r_vld;
    // pipeline advances unless the last stage holds an untaken item
    assign en = !r_vld[Lat-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
        end
    end

    logic signed [15:0] dx, dy, dz;
    assign dx = s_axis_tdata[15:0];
    assign dy = s_axis_tdata[31:16];
    assign dz = s_axis_tdata[47:32];

    // side data delayed alongside the length root (normals and ratio also the divider)
    logic [15:0] r_dd [0:2][0:LenLat-1];
    logic [56:0] r_nr [0:LenLat+DivLat-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dd[0][0] <= dx; r_dd[1][0] <= dy; r_dd[2][0] <= dz;
            r_nr[0] <= s_axis_tdata[104:48];
            for (int i = 1; i < LenLat; i++) begin
                for (int j = 0; j < 3; j++) r_dd[j][i] <= r_dd[j][i-1];
            end
            for (int i = 1; i < LenLat + DivLat; i++) r_nr[i] <= r_nr[i-1];
        end
    end

    logic [32:0] len2;
    logic [LenRootW-1:0] root;
    srv_len u_len (.i_clk(i_clk), .i_en(en), .i_dx(dx), .i_dy(dy), .i_dz(dz),
        .o_len2(len2), .o_root(root));

    logic r_zero [0:DivLat-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero[0] <= (len2 == '0);
            for (int i = 1; i < DivLat; i++) r_zero[i] <= r_zero[i-1];
        end
    end

    logic signed [UnitW-1:0] u [0:2];
    for (genvar j = 0; j < 3; j++) begin : g_div
        logic signed [15:0] dv;
        assign dv = r_dd[j][LenLat-1];
        srv_div u_div (.i_clk(i_clk), .i_en(en),
            .i_mag(dv[15] ? 16'(-dv) : 16'(dv)), .i_neg(dv[15]),
            .i_den((root == '0) ? LenRootW'(1) : root), .o_unit(u[j]));
    end

    logic [56:0] nr;
    assign nr = r_nr[LenLat+DivLat-1];
    logic signed [15:0] ox, oy, oz;
    logic ok;
    srv_snell u_sn (.i_clk(i_clk), .i_en(en), .i_zero(r_zero[DivLat-1]),
        .i_ux(u[0]), .i_uy(u[1]), .i_uz(u[2]),
        .i_nx(nr[13:0]), .i_ny(nr[27:14]), .i_nz(nr[41:28]), .i_r(nr[56:42]),
        .o_x(ox), .o_y(oy), .o_z(oz), .o_ok(ok));

    assign m_axis_tvalid = r_vld[Lat-1];
    assign m_axis_tdata = {7'b0, ok, oz, oy, ox};

    `SRV_ASSERT_IMPL(a_stall_blocks_input, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `SRV_ASSERT_NEXT(a_stall_holds_out, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `SRV_ASSERT_IMPL(a_invalid_is_zero, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tdata[48], m_axis_tdata[47:0] == 48'd0)
endmodule
`default_nettype wire
